// File: design/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
// Used by the controller, the datapath and the top level.
package lsc_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Outcode bits.
    localparam logic [3:0] CODE_LEFT   = 4'd1;
    localparam logic [3:0] CODE_RIGHT  = 4'd2;
    localparam logic [3:0] CODE_BOTTOM = 4'd4;
    localparam logic [3:0] CODE_TOP    = 4'd8;

    // Register indexes.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam int MAX_PASSES = 4;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture the input endpoints and their codes
        logic setup;     // form the operands of one pass
        logic mul;       // latch the product
        logic div_start; // launch the divider
        logic commit;    // write the moved endpoint back
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic all_in;    // both codes zero
        logic shared;    // codes share a bit
        logic div_done;
    } t_status;

endpackage

// File: design/lsc_divider.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing but its parameters.
module lsc_divider #(
    parameter int NUM_WIDTH = 34,
    parameter int DEN_WIDTH = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [NUM_WIDTH-1:0] o_quot
);
    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] r_quot;
    logic [DEN_WIDTH-1:0] r_den;
    logic [DEN_WIDTH:0]   r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_WIDTH:0]   n_shift;

    // Shift in the next numerator bit and try the subtraction.
    assign n_shift = {r_rem[DEN_WIDTH-1:0], r_quot[NUM_WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_WIDTH);
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem  <= n_shift - {1'b0, r_den};
                    r_quot <= {r_quot[NUM_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[NUM_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: design/lsc_datapath.sv
// Datapath: window registers, endpoints, outcodes, multiplier and divider.
// Depends on lsc_pkg and lsc_divider.
module lsc_datapath #(
    parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    input  logic [4*COORD_WIDTH-1:0] i_pts,
    input  lsc_pkg::t_cmd          i_cmd,
    output lsc_pkg::t_status       o_status,
    output logic [4*COORD_WIDTH-1:0] o_pts
);
    import lsc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;       // differences
    localparam int PW = 2 * DW;      // product

    logic signed [W-1:0] r_wl, r_wr, r_wb, r_wt;
    logic signed [W-1:0] r_xa, r_ya, r_xb, r_yb;
    logic [3:0]          r_ca, r_cb;

    logic signed [W-1:0] r_edge, r_p0;
    logic [DW-1:0]       r_mdp, r_mnum, r_mden;
    logic                r_neg, r_sel_b, r_vert, r_dz;
    logic [PW-1:0]       r_prod;
    logic [PW-1:0]       w_quot;
    logic                w_done;

    function automatic logic [3:0] outcode(
        input logic signed [W-1:0] x, input logic signed [W-1:0] y,
        input logic signed [W-1:0] wl, input logic signed [W-1:0] wr,
        input logic signed [W-1:0] wb, input logic signed [W-1:0] wt);
        logic [3:0] c;
        c = '0;
        if (x < wl) c = c | CODE_LEFT;
        if (x > wr) c = c | CODE_RIGHT;
        if (y < wb) c = c | CODE_BOTTOM;
        if (y > wt) c = c | CODE_TOP;
        return c;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // Pass operands from the current endpoints and codes.
    logic [3:0]           w_code;
    logic                 w_vert;
    logic signed [W-1:0]  w_edge, w_p0, w_p1, w_q0, w_q1;
    logic signed [DW-1:0] w_dp, w_num, w_den;
    always_comb begin
        w_code = (r_ca != 4'd0) ? r_ca : r_cb;
        w_vert = 1'b1;
        w_edge = r_wt;
        if ((w_code & CODE_LEFT) != 4'd0)        w_edge = r_wl;
        else if ((w_code & CODE_RIGHT) != 4'd0)  w_edge = r_wr;
        else if ((w_code & CODE_BOTTOM) != 4'd0) begin
            w_edge = r_wb; w_vert = 1'b0;
        end else w_vert = 1'b0;
        // Vertical edge: interpolate y over x; horizontal: x over y.
        w_p0 = w_vert ? r_ya : r_xa;
        w_p1 = w_vert ? r_yb : r_xb;
        w_q0 = w_vert ? r_xa : r_ya;
        w_q1 = w_vert ? r_xb : r_yb;
        w_dp  = DW'(w_p1) - DW'(w_p0);
        w_num = DW'(w_edge) - DW'(w_q0);
        w_den = DW'(w_q1) - DW'(w_q0);
    end

    lsc_divider #(.NUM_WIDTH(PW), .DEN_WIDTH(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_prod),
        .i_den  (r_mden),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // New point from the quotient.
    logic signed [W-1:0] w_other, w_nx, w_ny;
    always_comb begin
        if (r_dz) w_other = r_p0;
        else if (r_neg) w_other = r_p0 - W'(w_quot);
        else w_other = r_p0 + W'(w_quot);
        w_nx = r_vert ? r_edge : w_other;
        w_ny = r_vert ? w_other : r_edge;
    end

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= W'(100); r_wr <= W'(300);
            r_wb <= W'(100); r_wt <= W'(200);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEFT:   r_wl <= i_cfg_data;
                REG_RIGHT:  r_wr <= i_cfg_data;
                REG_BOTTOM: r_wb <= i_cfg_data;
                REG_TOP:    r_wt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Endpoint and pass registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xa <= i_pts[W-1:0];     r_ya <= i_pts[2*W-1:W];
            r_xb <= i_pts[3*W-1:2*W]; r_yb <= i_pts[4*W-1:3*W];
            r_ca <= outcode(i_pts[W-1:0], i_pts[2*W-1:W], r_wl, r_wr, r_wb, r_wt);
            r_cb <= outcode(i_pts[3*W-1:2*W], i_pts[4*W-1:3*W],
                            r_wl, r_wr, r_wb, r_wt);
        end
        if (i_cmd.setup) begin
            r_edge  <= w_edge;
            r_p0    <= w_p0;
            r_vert  <= w_vert;
            r_sel_b <= (r_ca == 4'd0);
            r_mdp   <= mag(w_dp);
            r_mnum  <= mag(w_num);
            r_mden  <= mag(w_den);
            r_dz    <= (w_den == '0);
            r_neg   <= (w_dp[DW-1] ^ w_num[DW-1]) ^ w_den[DW-1];
        end
        if (i_cmd.mul) r_prod <= r_mdp * r_mnum;
        if (i_cmd.commit) begin
            if (!r_sel_b) begin
                r_xa <= w_nx; r_ya <= w_ny;
                r_ca <= outcode(w_nx, w_ny, r_wl, r_wr, r_wb, r_wt);
            end else begin
                r_xb <= w_nx; r_yb <= w_ny;
                r_cb <= outcode(w_nx, w_ny, r_wl, r_wr, r_wb, r_wt);
            end
        end
    end

    assign o_status.all_in   = ((r_ca | r_cb) == 4'd0);
    assign o_status.shared   = ((r_ca & r_cb) != 4'd0);
    assign o_status.div_done = w_done;
    assign o_pts = {r_yb, r_xb, r_ya, r_xa};
endmodule

// File: design/lsc_controller.sv
// Controller: sequences load, clip passes and the result handoff.
// Depends on lsc_pkg.
module lsc_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_accepted,
    output logic             o_capture,
    input  lsc_pkg::t_status i_status,
    output lsc_pkg::t_cmd    o_cmd
);
    import lsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MUL, S_DIV, S_WAIT, S_COMMIT
    } t_state;

    t_state     r_state;
    logic [2:0] r_pass;
    logic       r_out_valid, r_accepted;
    logic       w_take, w_finish, w_acc;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_take     = i_in_valid && o_in_ready;
    // A finished word waits in the output register; the next item waits for it.
    assign w_finish = (r_state == S_CHECK) &&
                      (i_status.all_in || i_status.shared || r_pass >= 3'(MAX_PASSES));
    assign w_acc    = i_status.all_in;

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = w_take;
        o_cmd.setup     = (r_state == S_CHECK) && !w_finish;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.commit    = (r_state == S_COMMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    r_pass  <= '0;
                    r_state <= S_CHECK;
                end
                S_CHECK: if (w_finish) begin
                    r_out_valid <= 1'b1;
                    r_accepted  <= w_acc;
                    r_state     <= S_IDLE;
                end else r_state <= S_MUL;
                S_MUL:    r_state <= S_DIV;
                S_DIV:    r_state <= S_WAIT;
                S_WAIT:   if (i_status.div_done) r_state <= S_COMMIT;
                S_COMMIT: begin
                    r_pass  <= r_pass + 3'd1;
                    r_state <= S_CHECK;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_capture   = w_finish;
endmodule

// File: design/line_segment_clipper.sv
// Cohen-Sutherland line segment clipper, top level.
// Depends on lsc_pkg, lsc_controller and lsc_datapath.
//
// Usage:
//   s_axis carries one segment per word; m_axis returns one result word per
//   segment. The cfg channel writes the four window registers (index 0 left,
//   1 right, 2 bottom, 3 top); write only while no segment is in flight.
//   Each clip pass runs the serial divider, which produces one quotient bit
//   per cycle; a segment takes zero to four passes.
//   One segment is worked on at a time; a new one is taken once the previous
//   result has left the output register.
//   Reset (synchronous, active low) restores the window to left 100,
//   right 300, bottom 100, top 200 and drops any segment in flight.
//   When the receiver stalls, the result holds in the output register and
//   s_axis_tready stays low.
module line_segment_clipper #(
    parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [COORD_WIDTH-1:0]   cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y from the lowest bit up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // accepted
    output logic                     m_axis_tuser
);
    import lsc_pkg::*;

    localparam int PTS = 4 * COORD_WIDTH;
    localparam int TDW = ((PTS + 7) / 8) * 8;

    t_cmd     w_cmd;
    t_status  w_status;
    logic     w_capture;
    logic [PTS-1:0] w_pts;
    logic [PTS-1:0] r_out_pts;

    assign cfg_ready = 1'b1;

    lsc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_accepted (m_axis_tuser),
        .o_capture  (w_capture),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lsc_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_valid),
        .i_cfg_idx (cfg_index),
        .i_cfg_data(cfg_data),
        .i_pts     (s_axis_tdata[PTS-1:0]),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_pts     (w_pts)
    );

    // Output register for the result endpoints.
    always_ff @(posedge i_clk) begin
        if (w_capture) r_out_pts <= w_pts;
    end

    assign m_axis_tdata = TDW'(r_out_pts);
endmodule

// File: tb/sv/tb.sv
// Testbench for the line segment clipper: drives segments and window writes,
// predicts every clipped result and compares it word by word.
// Depends on lsc_pkg and line_segment_clipper.
`timescale 1ns / 1ps

module tb;
    import lsc_pkg::*;

    localparam int W = 16;

    typedef struct packed {
        logic [W-1:0] ey;
        logic [W-1:0] ex;
        logic [W-1:0] sy;
        logic [W-1:0] sx;
    } t_seg;

    typedef struct packed {
        logic         acc;
        logic [W-1:0] ey;
        logic [W-1:0] ex;
        logic [W-1:0] sy;
        logic [W-1:0] sx;
    } t_clip;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [W-1:0] cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [4*W-1:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [4*W-1:0] m_axis_tdata;
    logic         m_axis_tuser;

    line_segment_clipper #(.COORD_WIDTH(W)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Window as the predictor sees it.
    longint win_l = 100, win_r = 300, win_b = 100, win_t = 200;

    t_seg  seg_q[$];
    t_clip clip_q[$];
    int    errors = 0;
    int    n_checked = 0;
    int    n_accepted = 0;
    longint cycles = 0;
    bit    hold_off = 1'b0;

    function automatic longint sx16(logic [W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [3:0] region(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win_l) c |= CODE_LEFT;
        if (x > win_r) c |= CODE_RIGHT;
        if (y < win_b) c |= CODE_BOTTOM;
        if (y > win_t) c |= CODE_TOP;
        return c;
    endfunction

    // Exact interpolation; products fit in 64 bits at this width.
    function automatic longint lerp(longint p0, longint p1, longint q0, longint q1,
                                    longint e);
        longint den;
        den = q1 - q0;
        if (den == 0) return p0;
        return p0 + ((p1 - p0) * (e - q0)) / den;
    endfunction

    function automatic t_clip clip_segment(t_seg s);
        longint xa, ya, xb, yb, nx, ny;
        logic [3:0] ca, cb, code;
        t_clip r;
        xa = sx16(s.sx); ya = sx16(s.sy); xb = sx16(s.ex); yb = sx16(s.ey);
        ca = region(xa, ya); cb = region(xb, yb);
        r.acc = 1'b0;
        for (int pass = 0; ; pass++) begin
            if ((ca | cb) == 0) begin
                r.acc = 1'b1;
                break;
            end
            if ((ca & cb) != 0 || pass >= MAX_PASSES) break;
            code = (ca != 0) ? ca : cb;
            if (code & CODE_LEFT) begin
                nx = win_l; ny = lerp(ya, yb, xa, xb, nx);
            end else if (code & CODE_RIGHT) begin
                nx = win_r; ny = lerp(ya, yb, xa, xb, nx);
            end else if (code & CODE_BOTTOM) begin
                ny = win_b; nx = lerp(xa, xb, ya, yb, ny);
            end else begin
                ny = win_t; nx = lerp(xa, xb, ya, yb, ny);
            end
            if (ca != 0) begin
                xa = nx; ya = ny; ca = region(nx, ny);
            end else begin
                xb = nx; yb = ny; cb = region(nx, ny);
            end
        end
        r.sx = xa[W-1:0]; r.sy = ya[W-1:0]; r.ex = xb[W-1:0]; r.ey = yb[W-1:0];
        return r;
    endfunction

    // Driver: bursts with random gaps, fed from seg_q.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                clip_q.push_back(clip_segment(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (seg_q.size() > 0 && !hold_off) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= seg_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor with its own stall pattern on the receive side.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_clip got, want;
                got = {m_axis_tuser, m_axis_tdata};
                if (clip_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = clip_q.pop_front();
                    n_checked++;
                    if (want.acc) n_accepted++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: acc %b/%b start %h,%h/%h,%h end %h,%h/%h,%h",
                                     want.acc, got.acc, want.sx, want.sy, got.sx, got.sy,
                                     want.ex, want.ey, got.ex, got.ey);
                    end
                end
            end
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [W-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return W'($urandom);
            1: return W'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
            default: return W'($signed($urandom_range(0, 800)) - 200);
        endcase
    endfunction

    task automatic add_seg(int a, int b, int c, int d);
        t_seg s;
        s.sx = W'(a); s.sy = W'(b); s.ex = W'(c); s.ey = W'(d);
        seg_q.push_back(s);
    endtask

    // Waits until every queued segment has been answered and the block is idle.
    task automatic drain();
        while (seg_q.size() > 0 || s_axis_tvalid || clip_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // One register write, after which the channel is left idle.
    task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT:   win_l = sx16(val);
            REG_RIGHT:  win_r = sx16(val);
            REG_BOTTOM: win_b = sx16(val);
            default:    win_t = sx16(val);
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_window(int l, int r, int b, int t);
        write_reg(REG_LEFT, W'(l));
        write_reg(REG_RIGHT, W'(r));
        write_reg(REG_BOTTOM, W'(b));
        write_reg(REG_TOP, W'(t));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed segments against the reset window.
        add_seg(150, 150, 250, 180);       // fully inside
        add_seg(0, 150, 400, 150);         // crosses left and right
        add_seg(150, 0, 150, 300);         // crosses bottom and top
        add_seg(0, 0, 50, 50);             // trivially rejected, shared left
        add_seg(0, 250, 400, 50);          // diagonal, several passes
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, -32768, -32768, 32767);
        add_seg(0, 190, 120, 300);         // outside corner region, rejected after passes
        add_seg(100, 100, 300, 200);       // exactly on edges
        add_seg(-1, -1, -1, -1);
        add_seg(250, 150, 350, 260);       // one end outside
        drain();

        // Extreme and inverted windows.
        set_window(-32768, 32767, -32768, 32767);
        add_seg(-32768, 0, 32767, -1);
        add_seg(32767, 32767, -32768, -32768);
        drain();
        set_window(300, 100, 200, 100);    // inverted
        add_seg(0, 0, 400, 300);
        add_seg(200, 150, 210, 160);
        drain();
        set_window(0, 0, 0, 0);            // single point window
        add_seg(-5, -5, 5, 5);
        add_seg(-32768, 1, 32767, -1);
        drain();

        // Random phases with random windows.
        for (int ph = 0; ph < 8; ph++) begin
            int a, b;
            a = $signed(rnd_coord()); b = $signed(rnd_coord());
            if (ph % 3 != 2) begin
                if (a > b) begin int t; t = a; a = b; b = t; end
            end
            write_reg(REG_LEFT, W'(a));
            write_reg(REG_RIGHT, W'(b));
            a = $signed(rnd_coord()); b = $signed(rnd_coord());
            if (ph % 3 != 2) begin
                if (a > b) begin int t; t = a; a = b; b = t; end
            end
            write_reg(REG_BOTTOM, W'(a));
            write_reg(REG_TOP, W'(b));
            if (ph == 3) begin
                // Part way through, hold the sender until all results are back.
                for (int i = 0; i < 25; i++)
                    add_seg($signed(rnd_coord()), $signed(rnd_coord()),
                            $signed(rnd_coord()), $signed(rnd_coord()));
                while (seg_q.size() > 12) @(posedge i_clk);
                hold_off = 1'b1;
                while (clip_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                for (int i = 0; i < 50; i++)
                    add_seg($signed(rnd_coord()), $signed(rnd_coord()),
                            $signed(rnd_coord()), $signed(rnd_coord()));
            end
            drain();
        end

        $display("checked %0d segments, %0d accepted, across fixed, inverted and random windows",
                 n_checked, n_accepted);
        if (errors == 0 && clip_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
